// ===== design/sliding_window_send_budget_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the send budget checker
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SEND_BUDGET_MACROS_SVH
`define SLIDING_WINDOW_SEND_BUDGET_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SWSB_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("swsb check failed");

// next-cycle implication
`define SWSB_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("swsb check failed");

`endif

// ===== design/swsb_pkg.sv =====
// ----------------------------------------------------------------------------
// swsb_pkg
// Shared constants, codes and types of the sliding window send budget.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swsb_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int TIME_BITS   = 32;

  localparam int IDX_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W      = $clog2(STORE_DEPTH + 1);
  localparam int WIN_W      = 31;
  localparam int MAX_W      = 9;
  localparam int PRIO_W     = 3;
  localparam int USED_W     = 9;
  localparam int CFG_W      = 31;
  localparam int CFG_ADDR_W = 2;
  localparam int CMP_W      = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
  localparam int LIM_W      = (CNT_W > MAX_W) ? CNT_W : MAX_W;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SEND  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SEND_LIMIT     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SECONDS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BYPASS_LEVEL   = 2'd2;

  localparam logic [MAX_W-1:0]  MAX_RESET     = 9'd250;
  localparam logic [WIN_W-1:0]  WINDOW_RESET  = 31'd43200;
  localparam logic [PRIO_W-1:0] RESERVE_RESET = 3'd5;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [PRIO_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic              allowed;
    logic [USED_W-1:0] used_count;
    logic              store_overflow;
  } rsp_t;

  // chain control: pop shifts every cell toward the head, push loads one slot
  typedef struct packed {
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] slot;
  } chain_ctrl_t;

endpackage

// ===== design/sliding_window_send_budget.sv =====
// ----------------------------------------------------------------------------
// sliding_window_send_budget
// Rolling-window send limiter: seconds counter plus a shifting FIFO of
// timestamps of recent allowed sends.
// ----------------------------------------------------------------------------
//  channel   signals                          handshake
//  --------  -------------------------------  ------------------------------
//  request   req {cmd, priority_req}          taken when start && !busy
//  result    rsp {allowed, used_count, ovf}   one cycle, marked by done
//  config    cfg_addr, cfg_data               written when cfg_wr_en
//
//  Timing: tick, unused command and a send with limiting off answer the
//  cycle after they are taken and keep busy low, so they can run back to
//  back. Query and send hold busy in S_PRUNE while expired stamps are
//  popped, then answer; the chain pops one head cell per cycle.
//  Reset: synchronous rst clears count, time, FSM and registers to their
//  defaults; stamp cells are not cleared and need no clearing pass.
//  Stalls: the result side cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_send_budget (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  swsb_pkg::req_t                  req,
  output logic                            done,
  output swsb_pkg::rsp_t                  rsp,
  input  logic                            cfg_wr_en,
  input  logic [swsb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [swsb_pkg::CFG_W-1:0]      cfg_data
);
  import swsb_pkg::*;

  typedef enum logic {S_IDLE, S_PRUNE} state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  logic [TIME_BITS-1:0] now;
  logic [1:0]           cmd_q;
  logic [PRIO_W-1:0]    prio_q;

  logic [MAX_W-1:0]     send_limit;
  logic [WIN_W-1:0]     window_seconds;
  logic [PRIO_W-1:0]    bypass_level;

  logic [TIME_BITS-1:0] head_stamp;
  logic [TIME_BITS-1:0] age;
  logic                 expired;
  logic                 reserved;
  logic                 full;
  logic                 under_max;
  logic                 is_send;
  logic                 record;
  logic                 allow;
  logic                 overflow;
  logic [CNT_W-1:0]     count_next;
  chain_ctrl_t          ctrl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      send_limit     <= MAX_RESET;
      window_seconds <= WINDOW_RESET;
      bypass_level   <= RESERVE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_SEND_LIMIT:     send_limit     <= cfg_data[MAX_W-1:0];
        REG_WINDOW_SECONDS: window_seconds <= cfg_data[WIN_W-1:0];
        REG_BYPASS_LEVEL:   bypass_level   <= cfg_data[PRIO_W-1:0];
        default: ;
      endcase
    end
  end

  // head expiry: age taken modulo 2^TIME_BITS
  always_comb begin
    age       = now - head_stamp;
    expired   = (count != '0) && (CMP_W'(age) > CMP_W'(window_seconds));
    reserved  = (bypass_level != '0) && (prio_q >= bypass_level);
    full      = (count >= CNT_W'(STORE_DEPTH));
    under_max = (LIM_W'(count) < LIM_W'(send_limit));
    is_send   = (cmd_q == CMD_SEND);
    // a reserved send into a full store passes unrecorded
    record    = is_send && !full && (reserved || under_max);
    allow     = is_send && (reserved || (under_max && !full));
    overflow  = is_send && reserved && full;

    ctrl.pop  = (state == S_PRUNE) && expired;
    ctrl.push = (state == S_PRUNE) && !expired && record;
    ctrl.slot = count[IDX_W-1:0];

    count_next = count;
    if (ctrl.pop) begin
      count_next = count - CNT_W'(1);
    end else if (ctrl.push) begin
      count_next = count + CNT_W'(1);
    end
  end

  swsb_chain u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .now        (now),
    .head_stamp (head_stamp)
  );

  // control FSM and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      now    <= '0;
      done   <= 1'b0;
      cmd_q  <= CMD_TICK;
      prio_q <= '0;
      rsp    <= '0;
    end else begin
      done  <= 1'b0;
      count <= count_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q  <= req.cmd;
            prio_q <= req.priority_req;
            rsp.allowed        <= 1'b0;
            rsp.used_count     <= USED_W'(count);
            rsp.store_overflow <= 1'b0;
            case (req.cmd)
              CMD_TICK: begin
                now  <= now + TIME_BITS'(1);
                done <= 1'b1;
              end
              CMD_SEND: begin
                if (send_limit == '0) begin
                  // limiting off: pass, nothing pruned or recorded
                  rsp.allowed <= 1'b1;
                  done        <= 1'b1;
                end else begin
                  state <= S_PRUNE;
                end
              end
              CMD_QUERY: begin
                state <= S_PRUNE;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_PRUNE: begin
          if (!expired) begin
            state              <= S_IDLE;
            done               <= 1'b1;
            rsp.allowed        <= allow;
            rsp.used_count     <= USED_W'(count_next);
            rsp.store_overflow <= overflow;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== design/swsb_cell.sv =====
// ----------------------------------------------------------------------------
// swsb_cell
// One timestamp slot of the shifting stamp chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swsb_cell (
  input  logic                                clk,
  input  swsb_pkg::chain_ctrl_t               ctrl,
  input  logic [swsb_pkg::IDX_W-1:0]          slot_id,
  input  logic [swsb_pkg::TIME_BITS-1:0]      stamp_up,
  input  logic [swsb_pkg::TIME_BITS-1:0]      now,
  output logic [swsb_pkg::TIME_BITS-1:0]      stamp
);
  import swsb_pkg::*;

  // pop and push never share a cycle
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      stamp <= stamp_up;
    end else if (ctrl.push && (ctrl.slot == slot_id)) begin
      stamp <= now;
    end
  end

endmodule

// ===== design/swsb_chain.sv =====
// ----------------------------------------------------------------------------
// swsb_chain
// Row of stamp cells; cell 0 holds the oldest recorded send.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swsb_chain (
  input  logic                           clk,
  input  swsb_pkg::chain_ctrl_t          ctrl,
  input  logic [swsb_pkg::TIME_BITS-1:0] now,
  output logic [swsb_pkg::TIME_BITS-1:0] head_stamp
);
  import swsb_pkg::*;

  logic [TIME_BITS-1:0] stamps [STORE_DEPTH];

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    logic [TIME_BITS-1:0] up;
    // tail cell takes don't-care data on a pop
    if (i == STORE_DEPTH - 1) begin : g_tail
      assign up = now;
    end else begin : g_mid
      assign up = stamps[i+1];
    end

    swsb_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .slot_id  (IDX_W'(i)),
      .stamp_up (up),
      .now      (now),
      .stamp    (stamps[i])
    );
  end

  assign head_stamp = stamps[0];

endmodule

// ===== design/swsb_checker.sv =====
// ----------------------------------------------------------------------------
// swsb_checker
// Port-level checks of the send budget, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_send_budget_macros.svh"

module swsb_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input swsb_pkg::req_t req,
  input logic           done,
  input swsb_pkg::rsp_t rsp
);
  import swsb_pkg::*;

  // overflow only on a passing send into a full store
  `SWSB_ASSERT_NOW(a_ovf_allowed, done && rsp.store_overflow, rsp.allowed)
  `SWSB_ASSERT_NOW(a_ovf_full, done && rsp.store_overflow,
                   rsp.used_count == USED_W'(STORE_DEPTH))
  // a result always ends the item's work
  `SWSB_ASSERT_NOW(a_done_idle, done, !busy)
  // a tick answers next cycle and never passes
  `SWSB_ASSERT_NEXT(a_tick_rsp, start && !busy && (req.cmd == CMD_TICK),
                    done && !rsp.allowed && !busy)

endmodule

bind sliding_window_send_budget swsb_checker u_swsb_checker (.*);
